// ----- sv/sjs_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo joint slew stepper package
// Widths, register codes, reset values and the scaling constants shared by
// the modules of the slew stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package sjs_pkg;

	localparam int JOINT_COUNT = 6;
	localparam int ANGLE_MAX   = 180;

	localparam int JOINT_W     = 3;
	localparam int AMOUNT_W    = 9;
	localparam int ANGLE_W     = 8;
	localparam int STEP_W      = 8;
	localparam int PULSE_W     = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int SUM_W = 11;

	localparam logic signed [SUM_W-1:0] ANGLE_MAX_S = SUM_W'(ANGLE_MAX);

	// Division by ANGLE_MAX is a multiplication by a rounded-up reciprocal.
	// Eight spare bits in the shift keep the quotient exact over the whole
	// product range.
	localparam int PROD_W      = ANGLE_W + PULSE_W;
	localparam int RECIP_SHIFT = PROD_W + 8;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int WIDE_W      = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX));

	localparam logic [STEP_W-1:0]  STEP_LIMIT_RST    = STEP_W'(1);
	localparam logic [PULSE_W-1:0] PULSE_AT_ZERO_RST = PULSE_W'(150);
	localparam logic [PULSE_W-1:0] PULSE_AT_FULL_RST = PULSE_W'(600);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STEP_LIMIT    = 2'd0,
		REG_PULSE_AT_ZERO = 2'd1,
		REG_PULSE_AT_FULL = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0]  step_limit;
		logic [PULSE_W-1:0] pulse_at_zero;
		logic [PULSE_W-1:0] pulse_at_full;
	} cfg_t;

	typedef struct packed {
		logic [JOINT_W-1:0] channel;
		logic [ANGLE_W-1:0] angle;
	} angle_word_t;

endpackage

`default_nettype wire

// ----- sv/sjs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Slew stepper configuration registers
// Holds the step limit and the two pulse end points, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module sjs_cfg_regs
	import sjs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_limit    <= STEP_LIMIT_RST;
			cfg_q.pulse_at_zero <= PULSE_AT_ZERO_RST;
			cfg_q.pulse_at_full <= PULSE_AT_FULL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_LIMIT:    cfg_q.step_limit    <= cfg_data[STEP_W-1:0];
				REG_PULSE_AT_ZERO: cfg_q.pulse_at_zero <= cfg_data[PULSE_W-1:0];
				REG_PULSE_AT_FULL: cfg_q.pulse_at_full <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/sjs_angle_stage.sv -----
// ----------------------------------------------------------------------------
// Slew stepper angle stage
// Registers the command word, clamps the target, steps the stored joint angle
// toward it and writes the new angle back.
// ----------------------------------------------------------------------------
`default_nettype none

module sjs_angle_stage
	import sjs_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire logic                       op,
	input  wire logic [JOINT_W-1:0]         joint,
	input  wire logic signed [AMOUNT_W-1:0] amount,
	input  wire logic [STEP_W-1:0]          step_limit,
	output logic                            word_valid,
	input  wire logic                       word_take,
	output angle_word_t                     word
);

	logic                       valid_s1;
	logic                       op_s1;
	logic [JOINT_W-1:0]         joint_s1;
	logic signed [AMOUNT_W-1:0] amount_s1;

	logic                       valid_s2;
	angle_word_t                word_s2;

	logic [ANGLE_W-1:0]         angles_q [JOINT_COUNT];

	logic                       s2_free;
	logic                       s1_free;
	logic                       s1_adv;
	logic                       joint_ok;
	logic [ANGLE_W-1:0]         cur;
	logic signed [SUM_W-1:0]    amt_x;
	logic signed [SUM_W-1:0]    raw;
	logic [ANGLE_W-1:0]         tgt;
	logic [ANGLE_W:0]           up;
	logic [ANGLE_W-1:0]         gap;
	logic [ANGLE_W-1:0]         next_angle;

	assign s2_free   = !valid_s2 || word_take;
	assign s1_free   = !valid_s1 || s2_free;
	assign s1_adv    = valid_s1 && s2_free;
	assign cmd_stall = !s1_free;
	assign joint_ok  = {2'b00, joint} < 5'(JOINT_COUNT);

	assign word_valid = valid_s2;
	assign word       = word_s2;

	always_comb begin
		cur   = angles_q[joint_s1[IDX_W-1:0]];
		amt_x = SUM_W'(amount_s1);
		raw   = op_s1 ? (signed'(SUM_W'(cur)) + amt_x) : amt_x;
		if (raw < 0) begin
			tgt = '0;
		end else if (raw > ANGLE_MAX_S) begin
			tgt = ANGLE_MAX_S[ANGLE_W-1:0];
		end else begin
			tgt = raw[ANGLE_W-1:0];
		end
		up  = {1'b0, cur} + {1'b0, step_limit};
		gap = cur - tgt;
		if (cur < tgt) begin
			next_angle = (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
		end else if (cur > tgt) begin
			next_angle = (step_limit >= gap) ? tgt : (cur - step_limit);
		end else begin
			next_angle = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= cmd_valid && joint_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			op_s1     <= op;
			joint_s1  <= joint;
			amount_s1 <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			word_s2.channel <= joint_s1;
			word_s2.angle   <= next_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINT_COUNT; i++) begin
				angles_q[i] <= '0;
			end
		end else if (s1_adv) begin
			angles_q[joint_s1[IDX_W-1:0]] <= next_angle;
		end
	end

endmodule

`default_nettype wire

// ----- sv/sjs_scale_stage.sv -----
// ----------------------------------------------------------------------------
// Slew stepper pulse scaling stage
// Maps the new angle onto the pulse range: one multiply by the span, then a
// reciprocal multiply for the division, then the offset into the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sjs_scale_stage
	import sjs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                word_valid,
	output logic                     word_take,
	input  wire angle_word_t         word,
	input  wire cfg_t                cfg,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic [JOINT_W-1:0]       channel,
	output logic [PULSE_W-1:0]       pulse_width,
	output logic [ANGLE_W-1:0]       angle
);

	logic                 valid_s3;
	angle_word_t          word_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic                 neg_s3;

	logic                 res_valid_q;
	logic [JOINT_W-1:0]   channel_q;
	logic [PULSE_W-1:0]   pulse_q;
	logic [ANGLE_W-1:0]   angle_q;

	logic                 out_free;
	logic                 s3_free;
	logic                 span_neg;
	logic [PULSE_W-1:0]   span;
	logic [WIDE_W-1:0]    wide;
	logic [PULSE_W-1:0]   quot;

	assign out_free  = !res_valid_q || !res_stall;
	assign s3_free   = !valid_s3 || out_free;
	assign word_take = s3_free;

	assign span_neg = cfg.pulse_at_full < cfg.pulse_at_zero;
	assign span     = span_neg ? (cfg.pulse_at_zero - cfg.pulse_at_full)
	                           : (cfg.pulse_at_full - cfg.pulse_at_zero);
	assign wide     = WIDE_W'(prod_s3) * WIDE_W'(RECIP);
	assign quot     = wide[RECIP_SHIFT +: PULSE_W];

	assign res_valid   = res_valid_q;
	assign channel     = channel_q;
	assign pulse_width = pulse_q;
	assign angle       = angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			word_s3 <= word;
			prod_s3 <= PROD_W'(word.angle) * PROD_W'(span);
			neg_s3  <= span_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			channel_q <= word_s3.channel;
			angle_q   <= word_s3.angle;
			pulse_q   <= neg_s3 ? (cfg.pulse_at_zero - quot) : (cfg.pulse_at_zero + quot);
		end
	end

endmodule

`default_nettype wire

// ----- sv/servo_joint_slew_stepper.sv -----
// ----------------------------------------------------------------------------
// Servo joint slew stepper
// Slew-rate limited angle tracking for six servo joints with pulse mapping.
// ----------------------------------------------------------------------------
// Each command word names a joint and gives an absolute target or a signed
// relative step; the stored angle moves toward the clamped target by at most
// the step limit, and one result word carries the channel, the new angle and
// its pulse width. The block takes one command word per clock while
// cmd_stall is low and passes it through a four-register pipeline
// (command register, angle register, product register, result register);
// the stored angle is written back in the first stage, so commands to the
// same joint may follow each other back to back. A command naming a
// joint beyond the last one is consumed without a result. Configuration
// words should be written only while no command is in flight.
`default_nettype none

module servo_joint_slew_stepper
	import sjs_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire logic                       op,
	input  wire logic [JOINT_W-1:0]         joint,
	input  wire logic signed [AMOUNT_W-1:0] amount,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [JOINT_W-1:0]              channel,
	output logic [PULSE_W-1:0]              pulse_width,
	output logic [ANGLE_W-1:0]              angle
);

	cfg_t        cfg;
	logic        word_valid;
	logic        word_take;
	angle_word_t word;

	sjs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sjs_angle_stage u_angle_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.op         (op),
		.joint      (joint),
		.amount     (amount),
		.step_limit (cfg.step_limit),
		.word_valid (word_valid),
		.word_take  (word_take),
		.word       (word)
	);

	sjs_scale_stage u_scale_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word_take   (word_take),
		.word        (word),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.channel     (channel),
		.pulse_width (pulse_width),
		.angle       (angle)
	);

endmodule

`default_nettype wire
